// ----- rtl/wec_pkg.sv -----
// Shared types, constants and rounding helpers of the weighted elementwise combine unit.
`timescale 1ns / 1ps
package wec_pkg;

    localparam int DATA_WIDTH   = 16;
    localparam int MAX_INPUTS   = 4;
    localparam int ELEM_FIELDS  = 4;
    localparam int DATA_FRAC    = 8;
    localparam int WEIGHT_FRAC  = 12;
    localparam int WEIGHT_WIDTH = 16;
    localparam int OP_WIDTH     = 2;
    localparam int COUNT_WIDTH  = 3;
    localparam int INDEX_WIDTH  = 2;
    localparam int REG_IDX_W    = 3;

    // Largest usable number of inputs
    localparam int INPUT_CAP = (MAX_INPUTS < ELEM_FIELDS) ? MAX_INPUTS : ELEM_FIELDS;

    // Product of two data words, or of a weight and a data word
    localparam int PROD_W = 2 * DATA_WIDTH;
    // Sum of four products
    localparam int SUM_W  = PROD_W + 2;
    // Width after the rounding shift of a product, before clipping
    localparam int SAT_W  = PROD_W + 1 - DATA_FRAC;

    localparam logic [PROD_W:0] PROD_RND = (PROD_W + 1)'(2 ** (DATA_FRAC - 1));
    localparam logic [SUM_W:0]  SUM_RND  = (SUM_W + 1)'(2 ** (WEIGHT_FRAC - 1));

    localparam logic [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE  = WEIGHT_WIDTH'(2 ** WEIGHT_FRAC);
    localparam logic [COUNT_WIDTH-1:0]  COUNT_RESET = COUNT_WIDTH'(2);

    typedef enum logic [OP_WIDTH-1:0] {
        OP_PROD = 2'd0,
        OP_SUM  = 2'd1,
        OP_MAX  = 2'd2
    } t_op;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_OPERATION   = 3'd0,
        REG_INPUT_COUNT = 3'd1,
        REG_WEIGHT_0    = 3'd2,
        REG_WEIGHT_1    = 3'd3,
        REG_WEIGHT_2    = 3'd4,
        REG_WEIGHT_3    = 3'd5
    } t_reg_idx;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef t_data t_elems [ELEM_FIELDS];

    // Active configuration, count already clamped to the usable range
    typedef struct packed {
        logic [OP_WIDTH-1:0]                      op;
        logic [COUNT_WIDTH-1:0]                   count;
        logic [ELEM_FIELDS-1:0][WEIGHT_WIDTH-1:0] weight;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic [DATA_WIDTH-1:0]  value;
        logic [INDEX_WIDTH-1:0] index;
        logic                   sat;
    } t_res;

    // Clip to the data range; in range when all bits above the sign agree with it
    function automatic t_res sat_clip(input logic [SAT_W-1:0] v);
        t_res r;
        r.index = '0;
        if ((&v[SAT_W-1:DATA_WIDTH-1]) || !(|v[SAT_W-1:DATA_WIDTH-1])) begin
            r.value = v[DATA_WIDTH-1:0];
            r.sat   = 1'b0;
        end else begin
            r.value = v[SAT_W-1] ? DATA_MIN : DATA_MAX;
            r.sat   = 1'b1;
        end
        return r;
    endfunction

    // Q16.16 product to Q8.8, round half up, then clip
    function automatic t_res round_prod(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] t;
        t = {p[PROD_W-1], p} + PROD_RND;
        return sat_clip(t[PROD_W:DATA_FRAC]);
    endfunction

    // Q.20 sum to Q8.8, round half up, then clip
    function automatic t_res round_sum(input logic [SUM_W-1:0] s);
        logic [SUM_W:0]  t;
        logic [SAT_W-1:0] e;
        t = {s[SUM_W-1], s} + SUM_RND;
        e = SAT_W'($signed(t[SUM_W:WEIGHT_FRAC]));
        return sat_clip(e);
    endfunction

endpackage

// ----- rtl/wec_in_if.sv -----
// Input channel: one word of up to four elements.
`timescale 1ns / 1ps
interface wec_in_if import wec_pkg::*; ();
    logic  valid;
    logic  ready;
    t_data elem_zero;
    t_data elem_one;
    t_data elem_two;
    t_data elem_three;

    modport source (output valid, elem_zero, elem_one, elem_two, elem_three, input ready);
    modport sink   (input valid, elem_zero, elem_one, elem_two, elem_three, output ready);
endinterface

// ----- rtl/wec_out_if.sv -----
// Output channel: one combined result word.
`timescale 1ns / 1ps
interface wec_out_if import wec_pkg::*; ();
    logic                   valid;
    logic                   ready;
    t_data                  result_value;
    logic [INDEX_WIDTH-1:0] winner_index;
    logic                   saturated;

    modport source (output valid, result_value, winner_index, saturated, input ready);
    modport sink   (input valid, result_value, winner_index, saturated, output ready);
endinterface

// ----- rtl/wec_cfg_if.sv -----
// Configuration write channel: register index and data.
`timescale 1ns / 1ps
interface wec_cfg_if import wec_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [REG_IDX_W-1:0]    index;
    logic [WEIGHT_WIDTH-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/wec_cfg_regs.sv -----
// Configuration registers with input count clamping.
`timescale 1ns / 1ps
module wec_cfg_regs import wec_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_idle,
    wec_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    logic [OP_WIDTH-1:0]                      r_op;
    logic [COUNT_WIDTH-1:0]                   r_count;
    logic [ELEM_FIELDS-1:0][WEIGHT_WIDTH-1:0] r_weight;
    logic                                     w_wr;

    // Writes only land while no word is in flight
    assign i_cfg.ready = i_idle;
    assign w_wr        = i_cfg.valid && i_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= OP_SUM;
            r_count  <= COUNT_RESET;
            r_weight <= {ELEM_FIELDS{WEIGHT_ONE}};
        end else if (w_wr) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_OPERATION:   r_op        <= i_cfg.data[OP_WIDTH-1:0];
                REG_INPUT_COUNT: r_count     <= i_cfg.data[COUNT_WIDTH-1:0];
                REG_WEIGHT_0:    r_weight[0] <= i_cfg.data;
                REG_WEIGHT_1:    r_weight[1] <= i_cfg.data;
                REG_WEIGHT_2:    r_weight[2] <= i_cfg.data;
                REG_WEIGHT_3:    r_weight[3] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Clamp the count into two .. INPUT_CAP
    always_comb begin
        o_cfg.op     = r_op;
        o_cfg.weight = r_weight;
        if (r_count < COUNT_WIDTH'(2)) begin
            o_cfg.count = COUNT_WIDTH'(2);
        end else if (r_count > COUNT_WIDTH'(INPUT_CAP)) begin
            o_cfg.count = COUNT_WIDTH'(INPUT_CAP);
        end else begin
            o_cfg.count = r_count;
        end
    end

endmodule

// ----- rtl/wec_prod_lane.sv -----
// Product lane: chained multiply, round and clip, one multiplier per stage.
`timescale 1ns / 1ps
module wec_prod_lane import wec_pkg::*; (
    input  logic   i_clk,
    input  logic   i_adv,
    input  t_cfg   i_cfg,
    input  t_elems i_x,
    output t_res   o_res
);

    logic signed [PROD_W-1:0] r_p1, r_p2, r_p3;
    t_data                    r_x2, r_x3_s1, r_x3_s2;
    t_data                    r_v1, r_v2;
    logic                     r_sat1, r_sat2;

    t_res                     w_rc1, w_rc2, w_rc3;
    t_data                    w_v2;
    logic                     w_sat2;
    logic                     w_use2, w_use3;

    assign w_use2 = i_cfg.count > COUNT_WIDTH'(2);
    assign w_use3 = i_cfg.count > COUNT_WIDTH'(3);

    assign w_rc1  = round_prod(r_p1);
    assign w_rc2  = round_prod(r_p2);
    assign w_rc3  = round_prod(r_p3);

    // Second stage result only counts when input two is active
    assign w_v2   = w_use2 ? t_data'(w_rc2.value) : r_v1;
    assign w_sat2 = r_sat1 | (w_use2 & w_rc2.sat);

    // Stage 1: x0*x1
    // Stage 2: round, times x2
    // Stage 3: round, times x3
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p1    <= PROD_W'(i_x[0]) * PROD_W'(i_x[1]);
            r_x2    <= i_x[2];
            r_x3_s1 <= i_x[3];

            r_v1    <= t_data'(w_rc1.value);
            r_sat1  <= w_rc1.sat;
            r_p2    <= PROD_W'(t_data'(w_rc1.value)) * PROD_W'(r_x2);
            r_x3_s2 <= r_x3_s1;

            r_v2    <= w_v2;
            r_sat2  <= w_sat2;
            r_p3    <= PROD_W'(w_v2) * PROD_W'(r_x3_s2);
        end
    end

    // Final rounding of the last product
    always_comb begin
        o_res.index = '0;
        o_res.value = w_use3 ? w_rc3.value : r_v2;
        o_res.sat   = r_sat2 | (w_use3 & w_rc3.sat);
    end

endmodule

// ----- rtl/wec_sum_lane.sv -----
// Weighted sum lane: four weight products, adder tree, final round and clip.
`timescale 1ns / 1ps
module wec_sum_lane import wec_pkg::*; (
    input  logic   i_clk,
    input  logic   i_adv,
    input  t_cfg   i_cfg,
    input  t_elems i_x,
    output t_res   o_res
);

    logic signed [PROD_W-1:0] r_t [ELEM_FIELDS];
    logic signed [PROD_W:0]   r_s01, r_s23;
    logic signed [SUM_W-1:0]  r_tot;
    logic                     w_act [ELEM_FIELDS];

    always_comb begin
        for (int i = 0; i < ELEM_FIELDS; i++) begin
            w_act[i] = i_cfg.count > COUNT_WIDTH'(i);
        end
    end

    // Stage 1: products, inactive terms forced to zero
    // Stage 2: pair sums
    // Stage 3: total
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < ELEM_FIELDS; i++) begin
                r_t[i] <= w_act[i]
                    ? PROD_W'($signed(i_cfg.weight[i])) * PROD_W'(i_x[i])
                    : '0;
            end
            r_s01 <= (PROD_W + 1)'(r_t[0]) + (PROD_W + 1)'(r_t[1]);
            r_s23 <= (PROD_W + 1)'(r_t[2]) + (PROD_W + 1)'(r_t[3]);
            r_tot <= SUM_W'(r_s01) + SUM_W'(r_s23);
        end
    end

    assign o_res = round_sum(r_tot);

endmodule

// ----- rtl/wec_max_lane.sv -----
// Maximum lane: one compare per stage, index of the winner kept alongside.
`timescale 1ns / 1ps
module wec_max_lane import wec_pkg::*; (
    input  logic   i_clk,
    input  logic   i_adv,
    input  t_cfg   i_cfg,
    input  t_elems i_x,
    output t_res   o_res
);

    t_data                  r_m1, r_m2, r_m3;
    logic [INDEX_WIDTH-1:0] r_w1, r_w2, r_w3;
    t_data                  r_x2, r_x3_s1, r_x3_s2;
    logic                   w_take2, w_take3;

    // A later input wins only when strictly greater
    assign w_take2 = (i_cfg.count > COUNT_WIDTH'(2)) && (r_x2 > r_m1);
    assign w_take3 = (i_cfg.count > COUNT_WIDTH'(3)) && (r_x3_s2 > r_m2);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // Input one wins a tie with input zero
            if (i_x[0] > i_x[1]) begin
                r_m1 <= i_x[0];
                r_w1 <= INDEX_WIDTH'(0);
            end else begin
                r_m1 <= i_x[1];
                r_w1 <= INDEX_WIDTH'(1);
            end
            r_x2    <= i_x[2];
            r_x3_s1 <= i_x[3];

            r_m2    <= w_take2 ? r_x2 : r_m1;
            r_w2    <= w_take2 ? INDEX_WIDTH'(2) : r_w1;
            r_x3_s2 <= r_x3_s1;

            r_m3    <= w_take3 ? r_x3_s2 : r_m2;
            r_w3    <= w_take3 ? INDEX_WIDTH'(3) : r_w2;
        end
    end

    always_comb begin
        o_res.value = r_m3;
        o_res.index = r_w3;
        o_res.sat   = 1'b0;
    end

endmodule

// ----- rtl/weighted_eltwise_combine_unit.sv -----
// Top level of the weighted elementwise combine unit.
// Takes one word of up to four Q8.8 elements per cycle and returns one result word per
// input word, in order, after the three lane stages and the output register. Throughput is
// one word per cycle; the product chain has three multipliers, each in its own register
// stage, and the sum and maximum lanes run in parallel with the same depth; the mode
// register picks the lane in the output stage. A stalled output freezes the whole pipeline,
// and ready follows the output register, so a new word enters while a result is being
// taken. Configuration writes wait until the pipeline is empty and no word is offered.
`timescale 1ns / 1ps
module weighted_eltwise_combine_unit import wec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wec_in_if.sink     i_in,
    wec_out_if.source  o_out,
    wec_cfg_if.sink    i_cfg
);

    localparam int STAGES = 3;

    logic [STAGES-1:0] r_vld;
    logic              r_out_vld;
    t_res              r_out;
    t_res              n_out;

    t_cfg              w_cfg;
    t_elems            w_x;
    t_res              w_prod, w_sum, w_max;
    logic              w_adv;
    logic              w_idle;

    // Pipeline moves whenever the output register is free or being emptied
    assign w_adv   = !r_out_vld || o_out.ready;
    assign w_idle  = !(|r_vld) && !r_out_vld && !i_in.valid;
    assign i_in.ready = w_adv;

    assign w_x[0] = i_in.elem_zero;
    assign w_x[1] = i_in.elem_one;
    assign w_x[2] = i_in.elem_two;
    assign w_x[3] = i_in.elem_three;

    wec_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idle  (w_idle),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    wec_prod_lane u_prod (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_cfg (w_cfg),
        .i_x   (w_x),
        .o_res (w_prod)
    );

    wec_sum_lane u_sum (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_cfg (w_cfg),
        .i_x   (w_x),
        .o_res (w_sum)
    );

    wec_max_lane u_max (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_cfg (w_cfg),
        .i_x   (w_x),
        .o_res (w_max)
    );

    // Lane select by mode; unknown mode gives an all-zero word
    always_comb begin
        unique case (t_op'(w_cfg.op))
            OP_PROD: n_out = w_prod;
            OP_SUM:  n_out = w_sum;
            OP_MAX:  n_out = w_max;
            default: n_out = '0;
        endcase
    end

    // Valid bits travel with the lane stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[STAGES-2:0], i_in.valid};
            r_out_vld <= r_vld[STAGES-1];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.result_value = r_out.value;
    assign o_out.winner_index = r_out.index;
    assign o_out.saturated    = r_out.sat;

    // Only the maximum mode reports an index
    a_index_only_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (w_cfg.op != OP_MAX)) |-> (r_out.index == '0))
        else $error("winner index set outside maximum mode");

    // Maximum mode never clips
    a_max_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (w_cfg.op == OP_MAX)) |-> !r_out.sat)
        else $error("saturation flagged in maximum mode");

    // With two inputs the winner is input zero or one
    a_max_two_inputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (w_cfg.op == OP_MAX) && (w_cfg.count == COUNT_WIDTH'(2)))
            |-> !r_out.index[1])
        else $error("winner beyond active inputs");

    // No configuration write while a word is in flight
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready) |-> (!(|r_vld) && !r_out_vld))
        else $error("configuration write while busy");

endmodule
